### src/rsa_pkg.sv
// Shared widths and sequencer codes for the RTT statistics accumulator.
`default_nettype none
package rsa_pkg;
    localparam int SampleWidth = 24;
    localparam int CountWidth  = 24;
    localparam int FixWidth    = 32;
    localparam int SumWidth    = 64;
    localparam int FracBits    = 8;
    localparam int InBytes     = 6;
    localparam int OutBytes    = 21;

    localparam logic [23:0] CountMax = 24'hFFFFFF;
    localparam logic [23:0] SmoothDivisor = 24'd10;

    localparam int StateWidth = 4;
    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DIV_MEAN   = 4'd1;
    localparam logic [3:0] ST_MEAN_UPD   = 4'd2;
    localparam logic [3:0] ST_SQUARE     = 4'd3;
    localparam logic [3:0] ST_ACCUM      = 4'd4;
    localparam logic [3:0] ST_DIV_SMOOTH = 4'd5;
    localparam logic [3:0] ST_SMOOTH_UPD = 4'd6;
    localparam logic [3:0] ST_DIV_DEV    = 4'd7;
    localparam logic [3:0] ST_SQRT       = 4'd8;
    localparam logic [3:0] ST_DONE       = 4'd9;
endpackage
`default_nettype wire

### src/rtt_statistics_accumulator.sv
// RTT statistics accumulator: min, max, mean, deviation and smoothed average.
// The input is ready only in the idle state, so no new sample is taken while one is
// in work; a finished sample waits in ST_DONE while an earlier result is not yet taken.
// Later samples pass through one shared bit-serial unit: a 32-step mean division, a
// 36-step division by ten, a 64-step deviation division and a 32-step square root;
// the first sample takes only the deviation division and the square root.
// Reset (asynchronous, active low) clears all statistics and the output valid flag.
`default_nettype none
module rtt_statistics_accumulator
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // rtt_us [23:0], sent_count [47:24]
    input  wire logic [rsa_pkg::InBytes*8-1:0]  s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // received_total [23:0], min_rtt [47:24], max_rtt [71:48], mean_rtt [103:72],
    // mean_dev [135:104], smoothed_rtt [167:136]
    output logic [rsa_pkg::OutBytes*8-1:0] m_tdata
);
    import rsa_pkg::*;

    logic [StateWidth-1:0] state_reg, state_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [63:0] dq_reg, dq_next;
    logic [31:0] root_reg, root_next;
    logic [23:0] div_reg, div_next;
    logic [31:0] x_reg, x_next;
    logic        neg_reg, neg_next;
    logic [31:0] e_reg, e_next;
    logic [63:0] sq_reg, sq_next;

    logic [23:0] reply_count_reg, reply_count_next;
    logic [23:0] low_mark_reg, low_mark_next;
    logic [23:0] high_mark_reg, high_mark_next;
    logic [31:0] running_mean_reg, running_mean_next;
    logic [63:0] square_dev_sum_reg, square_dev_sum_next;
    logic [31:0] smoothed_value_reg, smoothed_value_next;

    logic        out_valid_reg, out_valid_next;
    logic [OutBytes*8-1:0] out_data_reg, out_data_next;

    logic [23:0] in_rtt;
    logic [23:0] in_sent;
    logic [31:0] in_x;
    logic        first;
    logic [25:0] div_shift;
    logic [25:0] div_diff;
    logic        div_bit;
    logic [33:0] sq_shift;
    logic [33:0] sq_trial;
    logic        sq_bit;
    logic [32:0] mean_sum;
    logic [31:0] new_mean;
    logic [64:0] acc_sum;
    logic [35:0] smooth_num;
    logic [35:0] smooth_quot;

    assign in_rtt   = s_tdata[23:0];
    assign in_sent  = s_tdata[47:24];
    assign in_x     = {in_rtt, 8'd0};
    assign first    = (reply_count_reg == 24'd0);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // One restoring division step: remainder stays below the 24-bit divisor.
    assign div_shift = {rem_reg[24:0], dq_reg[63]};
    assign div_diff  = div_shift - {2'b00, div_reg};
    assign div_bit   = (div_shift >= {2'b00, div_reg});

    // One digit-by-digit square root step, two radicand bits per cycle.
    assign sq_shift = {rem_reg[31:0], dq_reg[63:62]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_bit   = (sq_shift >= sq_trial);

    // The quotient never exceeds the distance to the sample, so no wrap occurs.
    assign mean_sum = neg_reg ? ({1'b0, running_mean_reg} - {1'b0, dq_reg[31:0]})
                              : ({1'b0, running_mean_reg} + {1'b0, dq_reg[31:0]});
    assign new_mean = mean_sum[31:0];
    assign acc_sum  = {1'b0, square_dev_sum_reg} + {1'b0, sq_reg};
    assign smooth_num = {4'd0, x_reg} + {1'b0, smoothed_value_reg, 3'd0}
                      + {4'd0, smoothed_value_reg} + 36'd5;
    assign smooth_quot = dq_reg[35:0];

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        dq_next = dq_reg;
        root_next = root_reg;
        div_next = div_reg;
        x_next = x_reg;
        neg_next = neg_reg;
        e_next = e_reg;
        sq_next = sq_reg;
        reply_count_next = reply_count_reg;
        low_mark_next = low_mark_reg;
        high_mark_next = high_mark_reg;
        running_mean_next = running_mean_reg;
        square_dev_sum_next = square_dev_sum_reg;
        smoothed_value_next = smoothed_value_reg;
        out_valid_next = out_valid_reg;
        out_data_next = out_data_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next = in_x;
                    div_next = (in_sent == 24'd0) ? 24'd1 : in_sent;
                    rem_next = '0;
                    if (reply_count_reg != CountMax)
                    begin
                        reply_count_next = reply_count_reg + 24'd1;
                    end
                    if (first)
                    begin
                        running_mean_next = in_x;
                        smoothed_value_next = in_x;
                        low_mark_next = in_rtt;
                        high_mark_next = in_rtt;
                        dq_next = square_dev_sum_reg;
                        cnt_next = 7'd63;
                        state_next = ST_DIV_DEV;
                    end
                    else
                    begin
                        if (in_rtt < low_mark_reg)
                        begin
                            low_mark_next = in_rtt;
                        end
                        if (in_rtt > high_mark_reg)
                        begin
                            high_mark_next = in_rtt;
                        end
                        neg_next = (in_x < running_mean_reg);
                        dq_next = (in_x < running_mean_reg)
                                ? {running_mean_reg - in_x, 32'd0}
                                : {in_x - running_mean_reg, 32'd0};
                        cnt_next = 7'd31;
                        state_next = ST_DIV_MEAN;
                    end
                end
            end
            ST_DIV_MEAN, ST_DIV_SMOOTH, ST_DIV_DEV:
            begin
                rem_next = {8'd0, div_bit ? div_diff : div_shift};
                dq_next = {dq_reg[62:0], div_bit};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    if (state_reg == ST_DIV_MEAN)
                    begin
                        state_next = ST_MEAN_UPD;
                    end
                    else if (state_reg == ST_DIV_SMOOTH)
                    begin
                        state_next = ST_SMOOTH_UPD;
                    end
                    else
                    begin
                        rem_next = '0;
                        root_next = '0;
                        cnt_next = 7'd31;
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_MEAN_UPD:
            begin
                running_mean_next = new_mean;
                e_next = (x_reg >= new_mean) ? (x_reg - new_mean) : (new_mean - x_reg);
                state_next = ST_SQUARE;
            end
            ST_SQUARE:
            begin
                sq_next = 64'(e_reg) * 64'(e_reg);
                state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                square_dev_sum_next = acc_sum[64] ? '1 : acc_sum[63:0];
                dq_next = {smooth_num, 28'd0};
                rem_next = '0;
                neg_next = 1'b0;
                cnt_next = 7'd35;
                state_next = ST_DIV_SMOOTH;
            end
            ST_SMOOTH_UPD:
            begin
                smoothed_value_next = (smooth_quot[35:32] != 4'd0) ? '1 : smooth_quot[31:0];
                dq_next = square_dev_sum_reg;
                rem_next = '0;
                cnt_next = 7'd63;
                state_next = ST_DIV_DEV;
            end
            ST_SQRT:
            begin
                rem_next = sq_bit ? (sq_shift - sq_trial) : sq_shift;
                root_next = {root_reg[30:0], sq_bit};
                dq_next = {dq_reg[61:0], 2'b00};
                cnt_next = cnt_reg - 7'd1;
                if (cnt_reg == 7'd0)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = {smoothed_value_reg, root_reg, running_mean_reg,
                                     high_mark_reg, low_mark_reg, reply_count_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        // The divisor for smoothing is the constant ten.
        if (state_reg == ST_ACCUM)
        begin
            div_next = SmoothDivisor;
        end
    end

    // The sent count is needed again after the smoothing division.
    logic [23:0] n_reg, n_next;
    always_comb
    begin
        n_next = n_reg;
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            n_next = (in_sent == 24'd0) ? 24'd1 : in_sent;
        end
    end

    logic [23:0] div_final;
    assign div_final = (state_reg == ST_SMOOTH_UPD) ? n_reg : div_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            reply_count_reg <= '0;
            low_mark_reg <= '0;
            high_mark_reg <= '0;
            running_mean_reg <= '0;
            square_dev_sum_reg <= '0;
            smoothed_value_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            reply_count_reg <= reply_count_next;
            low_mark_reg <= low_mark_next;
            high_mark_reg <= high_mark_next;
            running_mean_reg <= running_mean_next;
            square_dev_sum_reg <= square_dev_sum_next;
            smoothed_value_reg <= smoothed_value_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dq_reg <= dq_next;
        root_reg <= root_next;
        div_reg <= div_final;
        n_reg <= n_next;
        x_reg <= x_next;
        neg_reg <= neg_next;
        e_reg <= e_next;
        sq_reg <= sq_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a sample is in work");
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        low_mark_reg <= high_mark_reg)
        else $error("minimum above maximum");
    a_mean_low: assert property (@(posedge clk) disable iff (!rst_n)
        running_mean_reg >= {low_mark_reg, 8'd0})
        else $error("mean below smallest sample");
    a_mean_high: assert property (@(posedge clk) disable iff (!rst_n)
        running_mean_reg <= {high_mark_reg, 8'd0})
        else $error("mean above largest sample");
`endif
endmodule
`default_nettype wire

### verif/rtt_statistics_accumulator_tb.sv
// Self-checking testbench for the RTT statistics accumulator stream block.
`timescale 1ns / 1ps
module rtt_statistics_accumulator_tb;
    import rsa_pkg::*;

    typedef struct packed {
        logic [31:0] smoothed_rtt;
        logic [31:0] mean_dev;
        logic [31:0] mean_rtt;
        logic [23:0] max_rtt;
        logic [23:0] min_rtt;
        logic [23:0] received_total;
    } rtt_stats_t;

    typedef struct {
        logic [23:0] rtt;
        logic [23:0] sent;
        bit          typed;
        rtt_stats_t  stats;
    } stim_row_t;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles   = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [InBytes*8-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OutBytes*8-1:0] m_tdata;

    // Shadow copy of the accumulator statistics.
    logic [23:0] sh_count, sh_low, sh_high;
    logic [31:0] sh_mean, sh_smooth;
    logic [63:0] sh_sqsum;

    rtt_stats_t pending_stats[$];
    int errors = 0;
    int results_seen = 0;
    int idle_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always #1 clk = ~clk;

    rtt_statistics_accumulator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res[31:0];
    endfunction

    function automatic rtt_stats_t update_stats(logic [23:0] rtt, logic [23:0] sent);
        rtt_stats_t r;
        logic [63:0] n, x, m, nm, q, e, sq, s;
        logic first;
        n = (sent == 0) ? 64'd1 : {40'd0, sent};
        x = {32'd0, rtt, 8'd0};
        first = (sh_count == 0);
        if (sh_count != CountMax)
            sh_count = sh_count + 24'd1;
        if (first)
        begin
            sh_mean = x[31:0];
            sh_smooth = x[31:0];
            sh_low = rtt;
            sh_high = rtt;
        end
        else
        begin
            if (rtt < sh_low)
                sh_low = rtt;
            if (rtt > sh_high)
                sh_high = rtt;
            m = {32'd0, sh_mean};
            if (x >= m)
                nm = m + (x - m) / n;
            else
            begin
                q = (m - x) / n;
                nm = (q > m) ? 64'd0 : m - q;
            end
            if (nm > 64'hFFFF_FFFF)
                nm = 64'hFFFF_FFFF;
            sh_mean = nm[31:0];
            e = (x >= nm) ? x - nm : nm - x;
            if (e > 64'hFFFF_FFFF)
                e = 64'hFFFF_FFFF;
            sq = e * e;
            if (sh_sqsum > ~64'd0 - sq)
                sh_sqsum = ~64'd0;
            else
                sh_sqsum = sh_sqsum + sq;
            s = (x + 64'd9 * {32'd0, sh_smooth} + 64'd5) / 64'd10;
            if (s > 64'hFFFF_FFFF)
                s = 64'hFFFF_FFFF;
            sh_smooth = s[31:0];
        end
        r.received_total = sh_count;
        r.min_rtt = sh_low;
        r.max_rtt = sh_high;
        r.mean_rtt = sh_mean;
        r.mean_dev = int_sqrt(sh_sqsum / n);
        r.smoothed_rtt = sh_smooth;
        return r;
    endfunction

    // The valid flag stays up after a handshake; it drops only in an idle cycle
    // or once the caller has nothing more to send.
    task automatic send_sample(logic [23:0] rtt, logic [23:0] sent, bit typed,
                               rtt_stats_t typed_stats);
        rtt_stats_t predicted;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {sent, rtt};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = update_stats(rtt, sent);
        if (typed && typed_stats != predicted)
        begin
            $error("typed row disagrees: expected %h predicted %h", typed_stats, predicted);
            errors++;
        end
        pending_stats.push_back(typed ? typed_stats : predicted);
    endtask

    // Receiver side: random stalls and field-by-field comparison.
    always @(posedge clk)
    begin
        rtt_stats_t got, want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[167:0];
                results_seen++;
                if (pending_stats.size() == 0)
                begin
                    $error("result with nothing expected: %h", got);
                    errors++;
                end
                else
                begin
                    want = pending_stats.pop_front();
                    if (got.received_total != want.received_total)
                    begin
                        $error("received_total expected %0d actual %0d",
                               want.received_total, got.received_total);
                        errors++;
                    end
                    if (got.min_rtt != want.min_rtt)
                    begin
                        $error("min_rtt expected %0d actual %0d", want.min_rtt, got.min_rtt);
                        errors++;
                    end
                    if (got.max_rtt != want.max_rtt)
                    begin
                        $error("max_rtt expected %0d actual %0d", want.max_rtt, got.max_rtt);
                        errors++;
                    end
                    if (got.mean_rtt != want.mean_rtt)
                    begin
                        $error("mean_rtt expected %h actual %h", want.mean_rtt, got.mean_rtt);
                        errors++;
                    end
                    if (got.mean_dev != want.mean_dev)
                    begin
                        $error("mean_dev expected %h actual %h", want.mean_dev, got.mean_dev);
                        errors++;
                    end
                    if (got.smoothed_rtt != want.smoothed_rtt)
                    begin
                        $error("smoothed_rtt expected %h actual %h",
                               want.smoothed_rtt, got.smoothed_rtt);
                        errors++;
                    end
                end
            end
            m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("Watchdog expired");
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic rtt_stats_t mk(int cnt, int lo, int hi, longint mn, longint dv,
                                      longint sm);
        rtt_stats_t r;
        r.received_total = 24'(cnt);
        r.min_rtt = 24'(lo);
        r.max_rtt = 24'(hi);
        r.mean_rtt = 32'(mn);
        r.mean_dev = 32'(dv);
        r.smoothed_rtt = 32'(sm);
        return r;
    endfunction

    function automatic logic [23:0] rand_rtt();
        case ($urandom_range(3))
            0: return 24'($urandom_range(2000));
            1: return 24'($urandom_range(200000));
            2: return 24'($urandom);
            default: return $urandom_range(1) ? 24'hFFFFFF : 24'd0;
        endcase
    endfunction

    function automatic logic [23:0] rand_sent(logic [23:0] base);
        case ($urandom_range(5))
            0: return 24'd0;
            1: return 24'($urandom);
            2: return 24'($urandom_range(3) + 1);
            default: return base + 24'($urandom_range(3));
        endcase
    endfunction

    initial
    begin
        stim_row_t rows[$];
        logic [23:0] seq_sent;
        int phase;
        sh_count = 0; sh_low = 0; sh_high = 0;
        sh_mean = 0; sh_smooth = 0; sh_sqsum = 0;
        // After reset the first sample seeds the minimum, maximum, mean and smoothed value directly.
        rows.push_back('{24'd100, 24'd1, 1, mk(1, 100, 100, 25600, 0, 25600)});
        rows.push_back('{24'd0, 24'd0, 0, '0});
        rows.push_back('{24'hFFFFFF, 24'd3, 0, '0});
        rows.push_back('{24'hFFFFFF, 24'hFFFFFF, 0, '0});
        rows.push_back('{24'd1, 24'd2, 0, '0});
        rows.push_back('{24'd0, 24'hFFFFFF, 0, '0});
        rows.push_back('{24'h555555, 24'hAAAAAA, 0, '0});
        rows.push_back('{24'hAAAAAA, 24'h555555, 0, '0});
        rows.push_back('{24'd500, 24'd1, 0, '0});
        rows.push_back('{24'd400, 24'd0, 0, '0});
        for (int i = 0; i < 6; i++)
            rows.push_back('{24'hFFFFFF, 24'd1, 0, '0});
        for (int i = 0; i < 4; i++)
            rows.push_back('{24'd0, 24'd1, 0, '0});

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            send_sample(rows[i].rtt, rows[i].sent, rows[i].typed, rows[i].stats);
        s_tvalid <= 1'b0;

        // Hold off until the block has caught up on everything sent.
        while (pending_stats.size() != 0)
            @(posedge clk);

        seq_sent = 24'd20;
        for (int i = 0; i < 1200; i++)
        begin
            phase = (i / 150) % 4;
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 72; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 72; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            seq_sent = seq_sent + 24'd1;
            send_sample(rand_rtt(), rand_sent(seq_sent), 0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_stats.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("Covered %0d results: extreme samples, zero and huge sent counts,",
                 results_seen);
        $display("first-sample seeding, and four sender/receiver idling phases.");
        if (errors == 0 && pending_stats.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
